### rtl/lla_pkg.sv
// Shared types and constants for the life-like automaton grid.
// Holds the opcode and sequencer state enums and the rule word layout.
// No dependencies.
package lla_pkg;

    // Field widths
    localparam int OPCODE_W     = 3;
    localparam int COORD_W      = 8;
    localparam int GEN_W        = 32;
    localparam int RULE_W       = 18;
    localparam int RULE_IDX_W   = 5;
    localparam int COUNT_W      = 4;

    // Survival bits start here in the rule word
    localparam int SURVIVE_BASE = 9;

    // Defaults
    localparam int GRID_SIDE_DEF          = 32;
    localparam logic [RULE_W-1:0] RULE_RESET = 18'd6152;

    typedef enum logic [OPCODE_W-1:0] {
        OP_STEP   = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_SET    = 3'd2,
        OP_TOGGLE = 3'd3,
        OP_READ   = 3'd4
    } lla_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CELL_WR,
        S_LD1,
        S_LD2,
        S_SCAN,
        S_ROW_END,
        S_ROW_LD,
        S_DONE
    } lla_state_t;

endpackage

### rtl/life_like_automaton_grid.sv
// Life-like automaton grid: one-cell-per-cycle step unit over a row memory.
// A step takes the rows in turn through the single neighbor-count unit, which visits
// one cell a cycle, with a row-end write and a row fetch (S_ROW_END, S_ROW_LD) between rows.
// Clear, read, set, toggle and unused opcodes finish in S_DONE; one word is in flight at a time.
// Reset: row valid flags clear at once so every cell reads dead, no clearing pass;
// generation count is zero and the rule word is 6152.
module life_like_automaton_grid
#(
    parameter int GRID_SIDE = lla_pkg::GRID_SIDE_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [lla_pkg::OPCODE_W-1:0] opcode,
    input  logic [lla_pkg::COORD_W-1:0]  col,
    input  logic [lla_pkg::COORD_W-1:0]  row,
    input  logic                       new_value,
    // output channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       cell_value,
    output logic [lla_pkg::GEN_W-1:0]  generation,
    output logic                       off_grid,
    // configuration channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lla_pkg::RULE_W-1:0] rule_word
);
    import lla_pkg::*;

    localparam int ROW_W = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam logic [ROW_W-1:0] LAST_IDX = ROW_W'(GRID_SIDE - 1);

    lla_state_t state_reg, state_next;

    // latched operands and pending result
    lla_op_t              op_reg, op_next;
    logic [ROW_W-1:0]     col_idx_reg, col_idx_next;
    logic [ROW_W-1:0]     row_idx_reg, row_idx_next;
    logic                 val_reg, val_next;
    logic                 pend_cell_reg, pend_cell_next;
    logic                 pend_off_reg, pend_off_next;

    logic [GEN_W-1:0]     gen_reg, gen_next;
    logic [RULE_W-1:0]    rule_reg;
    logic [GRID_SIDE-1:0] row_valid_reg, row_valid_next;

    // row memory and its registered read port
    logic [GRID_SIDE-1:0] grid_mem [GRID_SIDE];
    logic [GRID_SIDE-1:0] grid_q_reg;
    logic                 q_valid_reg;
    logic [GRID_SIDE-1:0] row_data;
    logic [ROW_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [ROW_W-1:0]     wr_addr;
    logic [GRID_SIDE-1:0] wr_data;

    // line buffers and step counters
    logic [GRID_SIDE-1:0] above_reg, above_next;
    logic [GRID_SIDE-1:0] cur_reg, cur_next;
    logic [GRID_SIDE-1:0] below_reg, below_next;
    logic [GRID_SIDE-1:0] nrow_reg, nrow_next;
    logic [ROW_W-1:0]     rcnt_reg, rcnt_next;
    logic [ROW_W-1:0]     ccnt_reg, ccnt_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic                 out_cell_reg, out_cell_next;
    logic [GEN_W-1:0]     out_gen_reg, out_gen_next;
    logic                 out_off_reg, out_off_next;

    logic                 accept;
    logic                 in_off;
    logic                 ccnt_last;
    logic                 rcnt_last;
    logic [ROW_W:0]       row_plus2;
    logic                 plus2_in;
    logic                 left_ok;
    logic                 right_ok;
    logic [COUNT_W-1:0]   live_cnt;
    logic [RULE_IDX_W-1:0] rule_idx;
    logic                 new_bit;
    logic                 old_bit;
    logic                 mod_bit;
    logic                 out_free;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_off    = ({1'b0, col} >= (COORD_W+1)'(GRID_SIDE)) ||
                       ({1'b0, row} >= (COORD_W+1)'(GRID_SIDE));
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign cell_value = out_cell_reg;
    assign generation = out_gen_reg;
    assign off_grid   = out_off_reg;

    // Rows never written since reset or clear read as dead
    assign row_data = q_valid_reg ? grid_q_reg : '0;

    assign ccnt_last = (ccnt_reg == LAST_IDX);
    assign rcnt_last = (rcnt_reg == LAST_IDX);
    assign row_plus2 = {1'b0, rcnt_reg} + (ROW_W+1)'(2);
    assign plus2_in  = (row_plus2 < (ROW_W+1)'(GRID_SIDE));

    // Neighbor count for the cell at bit 0 of the rotating line buffers
    assign left_ok  = (ccnt_reg != '0);
    assign right_ok = !ccnt_last;
    assign live_cnt = COUNT_W'(above_reg[GRID_SIDE-1] & left_ok)
                    + COUNT_W'(above_reg[0])
                    + COUNT_W'(above_reg[1] & right_ok)
                    + COUNT_W'(cur_reg[GRID_SIDE-1] & left_ok)
                    + COUNT_W'(cur_reg[1] & right_ok)
                    + COUNT_W'(below_reg[GRID_SIDE-1] & left_ok)
                    + COUNT_W'(below_reg[0])
                    + COUNT_W'(below_reg[1] & right_ok);
    assign rule_idx = cur_reg[0] ? (RULE_IDX_W'(SURVIVE_BASE) + RULE_IDX_W'(live_cnt))
                                 : RULE_IDX_W'(live_cnt);
    assign new_bit  = rule_reg[rule_idx];

    // Single-cell update for set and toggle
    assign old_bit = row_data[col_idx_reg];
    assign mod_bit = (op_reg == OP_TOGGLE) ? ~old_bit : val_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (lla_op_t'(opcode))
                        OP_STEP:   state_next = S_LD1;
                        OP_SET,
                        OP_TOGGLE,
                        OP_READ:   state_next = in_off ? S_DONE : S_CELL_WR;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_CELL_WR: state_next = S_DONE;
            S_LD1:     state_next = S_LD2;
            S_LD2:     state_next = S_SCAN;
            S_SCAN:    state_next = ccnt_last ? S_ROW_END : S_SCAN;
            S_ROW_END: state_next = rcnt_last ? S_DONE : S_ROW_LD;
            S_ROW_LD:  state_next = S_SCAN;
            S_DONE:    state_next = out_free ? S_IDLE : S_DONE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        op_next        = op_reg;
        col_idx_next   = col_idx_reg;
        row_idx_next   = row_idx_reg;
        val_next       = val_reg;
        pend_cell_next = pend_cell_reg;
        pend_off_next  = pend_off_reg;
        gen_next       = gen_reg;
        row_valid_next = row_valid_reg;
        above_next     = above_reg;
        cur_next       = cur_reg;
        below_next     = below_reg;
        nrow_next      = nrow_reg;
        rcnt_next      = rcnt_reg;
        ccnt_next      = ccnt_reg;
        out_valid_next = out_valid_reg;
        out_cell_next  = out_cell_reg;
        out_gen_next   = out_gen_reg;
        out_off_next   = out_off_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = row_idx_reg;
        wr_data        = row_data;

        // drop the output word once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                // read the addressed row, or row 0 for a step
                rd_addr = (lla_op_t'(opcode) == OP_STEP) ? '0 : row[ROW_W-1:0];
                if (accept)
                begin
                    op_next        = lla_op_t'(opcode);
                    col_idx_next   = col[ROW_W-1:0];
                    row_idx_next   = row[ROW_W-1:0];
                    val_next       = new_value;
                    pend_cell_next = 1'b0;
                    pend_off_next  = 1'b0;
                    case (lla_op_t'(opcode))
                        OP_CLEAR:
                        begin
                            row_valid_next = '0;
                            gen_next       = '0;
                        end
                        OP_SET,
                        OP_TOGGLE,
                        OP_READ:
                        begin
                            pend_off_next = in_off;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CELL_WR:
            begin
                // modify one bit and write the row back, or only sample it for a read
                if (op_reg == OP_READ)
                begin
                    pend_cell_next = old_bit;
                end
                else
                begin
                    pend_cell_next       = mod_bit;
                    wr_en                = 1'b1;
                    wr_data              = row_data;
                    wr_data[col_idx_reg] = mod_bit;
                    row_valid_next[row_idx_reg] = 1'b1;
                end
            end
            S_LD1:
            begin
                // row 0 arrives, fetch row 1
                above_next = '0;
                cur_next   = row_data;
                rd_addr    = ROW_W'(1);
            end
            S_LD2:
            begin
                below_next = row_data;
                rcnt_next  = '0;
                ccnt_next  = '0;
            end
            S_SCAN:
            begin
                // rotate line buffers, shift in the new cell
                above_next = {above_reg[0], above_reg[GRID_SIDE-1:1]};
                cur_next   = {cur_reg[0], cur_reg[GRID_SIDE-1:1]};
                below_next = {below_reg[0], below_reg[GRID_SIDE-1:1]};
                nrow_next  = {new_bit, nrow_reg[GRID_SIDE-1:1]};
                ccnt_next  = ccnt_last ? '0 : ccnt_reg + ROW_W'(1);
            end
            S_ROW_END:
            begin
                // write finished row, advance line buffers, fetch two rows down; bump generation after the last row
                wr_en      = 1'b1;
                wr_addr    = rcnt_reg;
                wr_data    = nrow_reg;
                row_valid_next[rcnt_reg] = 1'b1;
                above_next = cur_reg;
                cur_next   = below_reg;
                rd_addr    = plus2_in ? row_plus2[ROW_W-1:0] : '0;
                if (rcnt_last)
                begin
                    gen_next = gen_reg + GEN_W'(1);
                end
            end
            S_ROW_LD:
            begin
                below_next = plus2_in ? row_data : '0;
                rcnt_next  = rcnt_reg + ROW_W'(1);
            end
            S_DONE:
            begin
                // hand the result to the output register
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cell_next  = pend_cell_reg;
                    out_gen_next   = gen_reg;
                    out_off_next   = pend_off_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gen_reg       <= '0;
            rule_reg      <= RULE_RESET;
            row_valid_reg <= '0;
            rcnt_reg      <= '0;
            ccnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            row_valid_reg <= row_valid_next;
            rcnt_reg      <= rcnt_next;
            ccnt_reg      <= ccnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                rule_reg <= rule_word;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        col_idx_reg   <= col_idx_next;
        row_idx_reg   <= row_idx_next;
        val_reg       <= val_next;
        pend_cell_reg <= pend_cell_next;
        pend_off_reg  <= pend_off_next;
        above_reg     <= above_next;
        cur_reg       <= cur_next;
        below_reg     <= below_next;
        nrow_reg      <= nrow_next;
        out_cell_reg  <= out_cell_next;
        out_gen_reg   <= out_gen_next;
        out_off_reg   <= out_off_next;
    end

    // Row memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            grid_mem[wr_addr] <= wr_data;
        end
        grid_q_reg  <= grid_mem[rd_addr];
        q_valid_reg <= row_valid_reg[rd_addr];
    end

endmodule
